// File: rtl/bae_pkg.sv
// Shared types and constants for the binary arithmetic encoder.
package bae_pkg;

  localparam int unsigned BoundW = 32;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxShifts = 4;
  localparam int unsigned CntW   = 3;

  localparam logic [ProbW-1:0]  ProbMin   = 16'd1;
  localparam logic [ProbW-1:0]  ProbMax   = 16'd65534;
  localparam logic [BoundW-1:0] LowReset  = 32'h0000_0000;
  localparam logic [BoundW-1:0] HighReset = 32'hffff_ffff;
  localparam logic [ByteW-1:0]  FillByte  = 8'hff;

  // Item actions
  localparam logic ActEncode = 1'b0;
  localparam logic ActFlush  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new item
    logic mul;        // form the two partial products
    logic update;     // split the interval and keep one side
    logic shift;      // emit agreeing top byte and shift bounds
    logic fin;        // emit top byte of the high bound (flush)
    logic emit_last;  // mark the emitted byte as last of its item
  } bae_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic flush;       // current item is a flush
    logic agree;       // top bytes of the bounds agree
    logic next_agree;  // second bytes agree (agreement after one shift)
  } bae_sts_t;

endpackage

// File: rtl/bae_datapath.sv
// Datapath: bounds, interval split and output byte register.
module bae_datapath
  import bae_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bae_cmd_t          cmd_i,
  output bae_sts_t          sts_o,
  input  logic              action_i,
  input  logic              bit_value_i,
  input  logic [ProbW-1:0]  prob_one_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              last_byte_o
);

  logic [BoundW-1:0] low_q, low_d;
  logic [BoundW-1:0] high_q, high_d;
  logic [BoundW-1:0] range_q;
  logic [2*ProbW-1:0] prod_hi_q, prod_lo_q;
  logic [ProbW-1:0]  prob_q, prob_clamped;
  logic              action_q;
  logic              bit_q;
  logic [ByteW-1:0]  byte_q;
  logic              last_q;
  logic [BoundW-1:0] split;

  // Clamp the probability into its legal range
  always_comb begin
    prob_clamped = prob_one_i;
    if (prob_one_i < ProbMin) begin
      prob_clamped = ProbMin;
    end else if (prob_one_i > ProbMax) begin
      prob_clamped = ProbMax;
    end
  end

  assign split = low_q + prod_hi_q + {{ProbW{1'b0}}, prod_lo_q[2*ProbW-1:ProbW]};

  // Next bounds
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (cmd_i.update) begin
      if (bit_q) begin
        high_d = split;
      end else begin
        low_d = split + 32'd1;
      end
    end else if (cmd_i.shift) begin
      low_d  = {low_q[BoundW-ByteW-1:0], {ByteW{1'b0}}};
      high_d = {high_q[BoundW-ByteW-1:0], FillByte};
    end
  end

  // Hold the bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowReset;
      high_q <= HighReset;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // Capture the item and form partial products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      bit_q    <= bit_value_i;
      prob_q   <= prob_clamped;
      range_q  <= high_q - low_q;
    end
    if (cmd_i.mul) begin
      prod_hi_q <= range_q[BoundW-1:ProbW] * prob_q;
      prod_lo_q <= range_q[ProbW-1:0] * prob_q;
    end
  end

  // Load the output byte on every transfer-bound emit
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift || cmd_i.fin) begin
      byte_q <= high_q[BoundW-1:BoundW-ByteW];
      last_q <= cmd_i.emit_last;
    end
  end

  assign sts_o.flush      = (action_q == ActFlush);
  assign sts_o.agree      = (low_q[BoundW-1:BoundW-ByteW] == high_q[BoundW-1:BoundW-ByteW]);
  assign sts_o.next_agree = (low_q[BoundW-ByteW-1:BoundW-2*ByteW]
                             == high_q[BoundW-ByteW-1:BoundW-2*ByteW]);
  assign out_byte_o       = byte_q;
  assign last_byte_o      = last_q;

endmodule

// File: rtl/bae_ctrl.sv
// Controller: sequences split, drain and flush, and owns the handshakes.
module bae_ctrl
  import bae_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  bae_sts_t sts_i,
  output bae_cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMul   = 2'd1;
  localparam logic [1:0] StUpd   = 2'd2;
  localparam logic [1:0] StDrain = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            in_accept;
  logic            can_shift;
  logic            drain_last;

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign can_shift  = sts_i.agree && (cnt_q < CntW'(MaxShifts));
  // Last drained byte of an encode: no agreement after it, or the bound is hit
  assign drain_last = !sts_i.flush
                      && (!sts_i.next_agree || (cnt_q == CntW'(MaxShifts - 1)));

  // Step the sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (in_accept) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        if (sts_i.flush) begin
          state_d = StDrain;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d      = StDrain;
      end
      StDrain: begin
        if (can_shift) begin
          if (out_free) begin
            cmd_o.shift     = 1'b1;
            cmd_o.emit_last = drain_last;
            cnt_d           = cnt_q + CntW'(1);
            if (drain_last) begin
              state_d = StIdle;
            end
          end
        end else if (sts_i.flush) begin
          if (out_free) begin
            cmd_o.fin       = 1'b1;
            cmd_o.emit_last = 1'b1;
            state_d         = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Track the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.shift || cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Never overwrite a byte that is still waiting for its transfer
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.shift || cmd_o.fin) |-> out_free)
    else $error("emit into a busy output register");

  // Shifts only happen on agreeing bounds, and never more than four per item
  a_shift_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.shift |-> (sts_i.agree && cnt_q < CntW'(MaxShifts)))
    else $error("shift without agreeing bounds");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxShifts))
    else $error("shift count out of range");

  // An accepted item moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StMul))
    else $error("accepted item did not start");

endmodule

// File: rtl/binary_arithmetic_encoder.sv
// Top level of the carry-less 32-bit binary arithmetic encoder.
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_stall_o  action_i, bit_value_i, prob_one_i
//  out      output     out_valid_o / out_stall_i out_byte_o, last_byte_o
//
// An encode item steps through capture, partial products and split, then the drain
// state emits its bytes. A flush goes from capture straight to the drain.
// Reset sets the low bound to zero and the high bound to all ones.
// A stalled output holds the byte and pauses the drain; input stays stalled until
// the current item has queued its last byte.
module binary_arithmetic_encoder
  import bae_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic             bit_value_i,
  input  logic [ProbW-1:0] prob_one_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_byte_o
);

  bae_cmd_t cmd;
  bae_sts_t sts;

  bae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bae_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .bit_value_i (bit_value_i),
    .prob_one_i  (prob_one_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// File: dv/bae_byte_checker.sv
// Channel monitor, output byte predictor and comparator for the arithmetic encoder.
`timescale 1ns / 100ps
module bae_byte_checker
  import bae_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             action_i,
  input  logic             bit_value_i,
  input  logic [ProbW-1:0] prob_one_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ByteW-1:0] out_byte_i,
  input  logic             last_byte_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] code;
    logic             last;
  } coded_byte_t;

  // Bytes still owed by the encoder, oldest first
  coded_byte_t       expected_bytes[$];
  logic [BoundW-1:0] low_q;
  logic [BoundW-1:0] high_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // Narrow the interval for one item, drain agreeing top bytes, queue them
  task automatic code_item(input logic act, input logic bv, input logic [ProbW-1:0] p_raw);
    logic [ProbW-1:0]  p;
    logic [BoundW-1:0] p32;
    logic [BoundW-1:0] span;
    logic [BoundW-1:0] cut;
    logic [ByteW-1:0]  drained [0:MaxShifts];
    int                n;
    coded_byte_t       entry;
    n = 0;
    if (act == ActEncode) begin
      p = p_raw;
      if (p < ProbMin) p = ProbMin;
      if (p > ProbMax) p = ProbMax;
      p32  = {16'h0000, p};
      span = high_q - low_q;
      cut  = low_q + (span >> 16) * p32 + (((span & 32'h0000_ffff) * p32) >> 16);
      if (bv) begin
        high_q = cut;
      end else begin
        low_q = cut + 32'd1;
      end
    end
    // Shift out bytes while the top bytes of the bounds agree
    while (n < MaxShifts && low_q[31:24] == high_q[31:24]) begin
      drained[n] = high_q[31:24];
      n++;
      low_q  = low_q << 8;
      high_q = {high_q[23:0], FillByte};
    end
    // Flush closes with the top byte of the high bound
    if (act == ActFlush) begin
      drained[n] = high_q[31:24];
      n++;
    end
    for (int k = 0; k < n; k++) begin
      entry.code = drained[k];
      entry.last = (k == n - 1);
      expected_bytes = {expected_bytes, entry};
    end
  endtask

  // Compare each output transfer, predict on each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    coded_byte_t want;
    if (!rst_ni) begin
      low_q  = LowReset;
      high_q = HighReset;
      expected_bytes.delete();
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte_i, last_byte_i));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_i !== want.code) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_i, want.code));
          end
          if (last_byte_i !== want.last) begin
            report_mismatch($sformatf("last_byte %0b, want %0b (byte %02h)",
                                      last_byte_i, want.last, want.code));
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        code_item(action_i, bit_value_i, prob_one_i);
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

// File: dv/tb_binary_arithmetic_encoder.sv
// Clock, reset, stimulus, output backpressure and verdict for the arithmetic encoder.
`timescale 1ns / 100ps
module tb_binary_arithmetic_encoder;
  import bae_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int RandomItems = 220;
  localparam int HoldCycles  = 80;
  localparam int TailCycles  = 16;

  // Receiver stall patterns
  localparam int StallNone   = 0;
  localparam int StallLight  = 1;
  localparam int StallHeavy  = 2;
  localparam int StallToggle = 3;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             action    = ActEncode;
  logic             bit_value = 1'b0;
  logic [ProbW-1:0] prob_one  = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             last_byte;
  int               fail_count;
  int               pending;
  bit               hold_off_req = 1'b0;
  int               burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_arithmetic_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .bit_value_i (bit_value),
    .prob_one_i  (prob_one),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .last_byte_o (last_byte)
  );

  bae_byte_checker byte_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .bit_value_i  (bit_value),
    .prob_one_i   (prob_one),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .last_byte_i  (last_byte),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one item at the falling edge and hold it until its transfer
  task automatic send_item(input logic act, input logic bv, input logic [ProbW-1:0] p);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      // Keep offering without gaps while the receiver holds off
      if (!hold_off_req) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    action    <= act;
    bit_value <= bv;
    prob_one  <= p;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Stimulus: directed items, then random traffic
  initial begin
    logic             act;
    logic             bv;
    logic [ProbW-1:0] p;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Clamped probabilities at both ends, each leaves the reset bounds
    send_item(ActEncode, 1'b1, 16'h0000);
    send_item(ActEncode, 1'b0, 16'hffff);
    send_item(ActEncode, 1'b1, 16'h0001);
    send_item(ActEncode, 1'b0, 16'hfffe);
    // Squeeze the interval across a byte boundary with no output bytes
    send_item(ActEncode, 1'b1, 16'h8001);
    send_item(ActEncode, 1'b0, 16'hfffe);
    send_item(ActEncode, 1'b1, 16'h0002);
    // Bounds collapse: drain the full four bytes
    send_item(ActEncode, 1'b1, 16'h0001);
    // Flush twice in a row, then keep coding on the same bounds
    send_item(ActFlush, 1'b0, 16'h0000);
    send_item(ActFlush, 1'b1, 16'hffff);
    send_item(ActEncode, 1'b0, 16'h8000);
    send_item(ActEncode, 1'b1, 16'h8000);
    send_item(ActEncode, 1'b0, 16'haaaa);
    send_item(ActEncode, 1'b1, 16'h5555);
    send_item(ActEncode, 1'b1, 16'hffff);
    send_item(ActEncode, 1'b0, 16'h0000);
    send_item(ActFlush, 1'b1, 16'h5555);
    wait_drained();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == 70 || i == 160) wait_drained();
      if (i == 110 || i == 190) hold_off_req = 1'b1;
      act = ($urandom_range(0, 11) == 0) ? ActFlush : ActEncode;
      case ($urandom_range(0, 7))
        0:       p = 16'($urandom_range(0, 3));
        1:       p = 16'hffff - 16'($urandom_range(0, 3));
        2:       p = 16'($urandom_range(0, 255));
        3:       p = 16'hffff - 16'($urandom_range(0, 255));
        default: p = 16'($urandom);
      endcase
      // Half the bits follow the stated probability, half are arbitrary
      if ($urandom_range(0, 1) == 0) begin
        bv = ($urandom_range(0, 65535) < p);
      end else begin
        bv = 1'($urandom_range(0, 1));
      end
      send_item(act, bv, p);
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver backpressure: a changing stall pattern plus requested long hold-offs
  initial begin
    int mode;
    int mode_left;
    mode      = StallNone;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(StallNone, StallToggle);
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      case (mode)
        StallNone:  out_stall <= 1'b0;
        StallLight: out_stall <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
        default:    out_stall <= ~out_stall;
      endcase
    end
  end

  // Watchdog: end the run after too many cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("status: fail");
    $finish;
  end

endmodule
